// ===== sv/lge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the B3/S23 rule for the Life generation engine.
package lge_pkg;

    // Neighbour count width (0..8)
    localparam int NBR_W = 4;

    // Birth needs exactly three live neighbours; survival needs two or three
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    // Dimension register width and APB register indexes
    localparam int DIM_W = 7;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef logic [NBR_W-1:0] t_nbr;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [5:0] row;
        logic [5:0] col;
        logic       value;
    } t_in_item;

    typedef struct packed {
        logic       alive;
        logic       will_live;
        t_nbr       neighbour_count;
        logic       out_of_range;
    } t_out_item;

    // Effective (clamped) grid dimensions
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_dims;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WR_RD,
        S_WR_WR,
        S_ADV_RD0,
        S_ADV_LOAD,
        S_ADV_ROW,
        S_CLR,
        S_Q_UP,
        S_Q_MID,
        S_Q_DN,
        S_EVAL
    } t_state;

    // B3/S23 rule
    function automatic logic live_rule(input logic alive, input t_nbr n);
        if (alive) begin
            return (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
        end
        return (n == BIRTH_COUNT);
    endfunction

endpackage

// ===== sv/life_generation_engine_top.sv =====
`timescale 1ns / 1ps
// Top level of the Life generation engine (B3/S23 on a bounded grid).
//
// The grid lives in a single-port-write, registered-read memory of MAX_ROWS
// words of MAX_COLS bits, and all cell arithmetic is done by one row unit
// that evaluates a whole row word at a time. One transaction is worked on
// at a time; the input is stalled until its result sits in the output
// register, which may still be waiting when the next transaction is taken.
// Per transaction: a query reads the rows around the cell and evaluates; a
// write of a cell in the grid first rewrites its row; advance generation
// sweeps the rows in use, one row per cycle through the memory; clear writes
// all MAX_ROWS words. An address outside the grid in use goes straight to the
// result (advance and clear still run their sweeps). After reset a clearing
// pass runs before the first transaction; register writes are taken at once.
module life_generation_engine_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lge_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lge_pkg::t_out_item   o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lge_pkg::*;

    t_dims w_dims;

    // Configuration registers
    lge_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (w_dims)
    );

    // Sequencer, grid memory and row unit
    lge_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_dims      (w_dims)
    );

endmodule

// ===== sv/lge_row_unit.sv =====
`timescale 1ns / 1ps
// Row evaluation unit: neighbour counts and next states for one grid row.
module lge_row_unit #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0]                 i_above,
    input  logic [MAX_COLS-1:0]                 i_cur,
    input  logic [MAX_COLS-1:0]                 i_below,
    input  logic [lge_pkg::DIM_W-1:0]           i_cols,
    output logic [MAX_COLS-1:0][lge_pkg::NBR_W-1:0] o_counts,
    output logic [MAX_COLS-1:0]                 o_next
);
    import lge_pkg::*;

    logic [MAX_COLS-1:0] w_mask;
    logic [MAX_COLS-1:0] w_a;
    logic [MAX_COLS-1:0] w_c;
    logic [MAX_COLS-1:0] w_b;

    // Columns outside the area in use count as dead
    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            w_mask[j] = (DIM_W'(j) < i_cols);
        end
        w_a = i_above & w_mask;
        w_c = i_cur   & w_mask;
        w_b = i_below & w_mask;
    end

    // Per-column sum of the eight neighbours, then the rule; no wrap at the edges
    always_comb begin
        t_nbr sum;
        for (int j = 0; j < MAX_COLS; j++) begin
            sum = {3'b000, w_a[j]} + {3'b000, w_b[j]};
            if (j > 0) begin
                sum = sum + {3'b000, w_a[j-1]} + {3'b000, w_c[j-1]} + {3'b000, w_b[j-1]};
            end
            if (j < MAX_COLS - 1) begin
                sum = sum + {3'b000, w_a[j+1]} + {3'b000, w_c[j+1]} + {3'b000, w_b[j+1]};
            end
            o_counts[j] = sum;
            // cells beyond the area in use keep their state
            o_next[j]   = w_mask[j] ? live_rule(w_c[j], sum) : i_cur[j];
        end
    end

endmodule

// ===== sv/lge_cfg.sv =====
`timescale 1ns / 1ps
// APB register block: raw dimension registers and their clamped values.
module lge_cfg #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lge_pkg::t_dims       o_dims
);
    import lge_pkg::*;

    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes; the stored bits are kept as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows <= pwdata[DIM_W-1:0];
            end else begin
                r_cols <= pwdata[DIM_W-1:0];
            end
        end
    end

    // Read mux
    always_comb begin
        if (paddr[2] == REG_COLS) begin
            prdata = {{(32-DIM_W){1'b0}}, r_cols};
        end else begin
            prdata = {{(32-DIM_W){1'b0}}, r_rows};
        end
    end

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        if (r_rows == '0) begin
            o_dims.rows = DIM_W'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            o_dims.rows = DIM_W'(MAX_ROWS);
        end else begin
            o_dims.rows = r_rows;
        end
        if (r_cols == '0) begin
            o_dims.cols = DIM_W'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            o_dims.cols = DIM_W'(MAX_COLS);
        end else begin
            o_dims.cols = r_cols;
        end
    end

endmodule

// ===== sv/lge_seq.sv =====
`timescale 1ns / 1ps
// Sequencer with the grid memory: runs each operation through the row unit.
module lge_seq #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lge_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lge_pkg::t_out_item   o_out_item,
    input  lge_pkg::t_dims       i_dims
);
    import lge_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int CW  = (AW >= 7) ? AW + 1 : 8;
    localparam logic [CW-1:0] LAST_ROW = CW'(MAX_ROWS - 1);

    // Grid store, one row per word
    logic [MAX_COLS-1:0] mem [MAX_ROWS];

    t_state              r_state, n_state;
    t_in_item            r_item;
    logic                r_inside;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_cur, n_cur;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;

    logic                w_accept;
    logic                w_inside_now;
    logic                w_out_free;
    logic                w_out_load;
    logic [CW-1:0]       w_nr;
    logic [CW-1:0]       w_q;
    logic [CW-1:0]       w_below_row;
    logic [MAX_COLS-1:0] w_below;
    logic [MAX_COLS-1:0] w_bit;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_wa;
    logic [MAX_COLS-1:0] w_mem_wd;
    logic [CW-1:0]       w_mem_ra;
    logic [CAW-1:0]      w_c;

    logic [MAX_COLS-1:0][NBR_W-1:0] w_counts;
    logic [MAX_COLS-1:0]            w_next;

    assign w_nr         = CW'(i_dims.rows);
    assign w_q          = CW'(r_item.row);
    assign w_c          = r_item.col[CAW-1:0];
    assign w_inside_now = (CW'(i_in_item.row) < w_nr) &&
                          ({1'b0, i_in_item.col} < i_dims.cols);
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_bit        = MAX_COLS'(1) << w_c;

    // Row below the one being evaluated; rows outside the grid in use read as dead
    assign w_below_row = (r_state == S_EVAL) ? (w_q + CW'(1)) : (r_cnt + CW'(1));
    assign w_below     = (w_below_row < w_nr) ? r_rd_data : '0;

    lge_row_unit #(
        .MAX_COLS (MAX_COLS)
    ) u_row (
        .i_above  (r_prev),
        .i_cur    (r_cur),
        .i_below  (w_below),
        .i_cols   (i_dims.cols),
        .o_counts (w_counts),
        .o_next   (w_next)
    );

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_wa] <= w_mem_wd;
        end
        r_rd_data <= mem[w_mem_ra[AW-1:0]];
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cur  <= n_cur;
        if (w_accept) begin
            r_item   <= i_in_item;
            r_inside <= w_inside_now;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_prev     = r_prev;
        n_cur      = r_cur;
        w_mem_we   = 1'b0;
        w_mem_wa   = r_cnt[AW-1:0];
        w_mem_wd   = '0;
        w_mem_ra   = r_cnt;
        w_out_load = 1'b0;
        case (r_state)
            S_INIT: begin
                // clearing pass after reset
                w_mem_we = 1'b1;
                if (r_cnt == LAST_ROW) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt = '0;
                    case (i_in_item.operation)
                        OP_WRITE:   n_state = w_inside_now ? S_WR_RD : S_EVAL;
                        OP_QUERY:   n_state = w_inside_now ? S_Q_UP : S_EVAL;
                        OP_ADVANCE: n_state = S_ADV_RD0;
                        OP_CLEAR:   n_state = S_CLR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_WR_RD: begin
                w_mem_ra = w_q;
                n_state  = S_WR_WR;
            end
            S_WR_WR: begin
                // read-modify-write of the addressed row
                w_mem_we = 1'b1;
                w_mem_wa = w_q[AW-1:0];
                w_mem_wd = r_item.value ? (r_rd_data | w_bit) : (r_rd_data & ~w_bit);
                n_state  = S_Q_UP;
            end
            S_ADV_RD0: begin
                w_mem_ra = '0;
                n_state  = S_ADV_LOAD;
            end
            S_ADV_LOAD: begin
                n_prev   = '0;
                n_cur    = r_rd_data;
                w_mem_ra = CW'(1);
                n_cnt    = '0;
                n_state  = S_ADV_ROW;
            end
            S_ADV_ROW: begin
                // old rows stay in the window registers, new row goes back in place
                w_mem_we = 1'b1;
                w_mem_wa = r_cnt[AW-1:0];
                w_mem_wd = w_next;
                n_prev   = r_cur;
                n_cur    = w_below;
                w_mem_ra = r_cnt + CW'(2);
                if ((r_cnt + CW'(1)) == w_nr) begin
                    n_state = r_inside ? S_Q_UP : S_EVAL;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_CLR: begin
                w_mem_we = 1'b1;
                if (r_cnt == LAST_ROW) begin
                    n_cnt   = '0;
                    n_state = r_inside ? S_Q_UP : S_EVAL;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_Q_UP: begin
                w_mem_ra = w_q - CW'(1);
                n_state  = S_Q_MID;
            end
            S_Q_MID: begin
                n_prev   = (w_q != '0) ? r_rd_data : '0;
                w_mem_ra = w_q;
                n_state  = S_Q_DN;
            end
            S_Q_DN: begin
                n_cur    = r_rd_data;
                w_mem_ra = w_q + CW'(1);
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                // hold the read of the row below while the result slot is full
                w_mem_ra = w_q + CW'(1);
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result for the addressed cell
    always_comb begin
        if (r_inside) begin
            n_out.alive           = r_cur[w_c];
            n_out.will_live       = w_next[w_c];
            n_out.neighbour_count = w_counts[w_c];
            n_out.out_of_range    = 1'b0;
        end else begin
            n_out.alive           = 1'b0;
            n_out.will_live       = 1'b0;
            n_out.neighbour_count = '0;
            n_out.out_of_range    = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("engine not busy after taking a transaction");

    a_eval_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && w_out_free |=> r_out_valid)
        else $error("result not presented after evaluation");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_INIT) || (r_state == S_CLR) ||
                     (r_state == S_WR_WR) || (r_state == S_ADV_ROW))
        else $error("grid written outside a writing state");

    a_adv_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_ROW) |-> (r_cnt < w_nr))
        else $error("generation sweep ran past the rows in use");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.out_of_range |->
            !r_out.alive && !r_out.will_live && (r_out.neighbour_count == '0))
        else $error("out-of-range result carries cell data");

endmodule
